[src/ptc_pkg.sv]
package ptc_pkg;

    localparam int unsigned ADC_W      = 20;
    localparam int unsigned RES_W      = 32;
    localparam int unsigned DIV_W      = 64;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned TCAL_W     = 48;
    localparam int unsigned COEF_W     = 16;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_CAL   = 3'd0,
        CFG_PRESS_LO   = 3'd1,
        CFG_PRESS_HI   = 3'd2,
        CFG_PRESS_NINE = 3'd3,
        CFG_FORMULA    = 3'd4
    } cfg_index_t;

    // per-sample data that rides alongside the divider
    typedef struct packed {
        logic [RES_W-1:0] temp;
        logic [RES_W-1:0] fine;
        logic             zero;
        logic             neg;
        logic             dbl;
    } ptc_side_t;

    function automatic logic [31:0] sx32(input logic [COEF_W-1:0] c);
        return {{16{c[COEF_W-1]}}, c};
    endfunction

    function automatic logic [63:0] sx64(input logic [COEF_W-1:0] c);
        return {{48{c[COEF_W-1]}}, c};
    endfunction

endpackage

[src/ptc_in_if.sv]
interface ptc_in_if
    import ptc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_pressure;
    logic [ADC_W-1:0] adc_temperature;

    modport source (output valid, adc_pressure, adc_temperature, input ready);
    modport sink   (input valid, adc_pressure, adc_temperature, output ready);
endinterface

[src/ptc_out_if.sv]
interface ptc_out_if
    import ptc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] temperature_centi;
    logic [RES_W-1:0] fine_temperature;
    logic [RES_W-1:0] pressure_value;
    logic             divisor_zero;

    modport source (output valid, temperature_centi, fine_temperature, pressure_value,
                    divisor_zero, input ready);
    modport sink   (input valid, temperature_centi, fine_temperature, pressure_value,
                    divisor_zero, output ready);
endinterface

[src/pressure_temperature_compensation.sv]
// pressure and temperature compensation pipeline
//
// in_ch (sink) carries one raw 20-bit pressure and temperature pair per transaction.
// out_ch (source) returns one result per transaction: temperature in 0.01 degC,
// fine temperature, pressure (q24.8 pa or whole pa per formula select) and a
// flag that marks a zero pressure divisor (pressure then reads 0).
// calibration and formula select are written on cfg_wen/cfg_index/cfg_wdata; the user
// must do so only while no transaction is in flight, the block does not enforce it.
// indexes above the register map are dropped.
// structure: 9 front stages, 64-stage restoring divider at one quotient bit per stage,
// 4 back stages, output reg.
// throughput: one transaction per cycle while the output is not stalled; the divider chain sets the depth.
// stall: when the output holds a result that is not taken, the whole pipe
// freezes and in_ch.ready drops; nothing is lost or repeated.
// reset: clears valid bits and all configuration registers to zero.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ptc_in_if.sink                in_ch,
    ptc_out_if.source             out_ch,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic [TCAL_W-1:0]     temp_cal_reg;
    logic [CFG_DATA_W-1:0] press_lo_reg;
    logic [CFG_DATA_W-1:0] press_hi_reg;
    logic [COEF_W-1:0]     press_nine_reg;
    logic                  formula_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg   <= '0;
            press_lo_reg   <= '0;
            press_hi_reg   <= '0;
            press_nine_reg <= '0;
            formula_reg    <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_TEMP_CAL:   temp_cal_reg   <= cfg_wdata[TCAL_W-1:0];
                CFG_PRESS_LO:   press_lo_reg   <= cfg_wdata;
                CFG_PRESS_HI:   press_hi_reg   <= cfg_wdata;
                CFG_PRESS_NINE: press_nine_reg <= cfg_wdata[COEF_W-1:0];
                CFG_FORMULA:    formula_reg    <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    // calibration coefficients
    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] p1_32, p2_32, p3_32, p4_32, p5_32, p6_32, p7_32, p8_32, p9_32;

    assign t1 = {16'd0, temp_cal_reg[15:0]};
    assign t2 = sx32(temp_cal_reg[31:16]);
    assign t3 = sx32(temp_cal_reg[47:32]);
    assign p1 = {48'd0, press_lo_reg[15:0]};
    assign p2 = sx64(press_lo_reg[31:16]);
    assign p3 = sx64(press_lo_reg[47:32]);
    assign p4 = sx64(press_lo_reg[63:48]);
    assign p5 = sx64(press_hi_reg[15:0]);
    assign p6 = sx64(press_hi_reg[31:16]);
    assign p7 = sx64(press_hi_reg[47:32]);
    assign p8 = sx64(press_hi_reg[63:48]);
    assign p9 = sx64(press_nine_reg);
    assign p1_32 = p1[31:0];
    assign p2_32 = p2[31:0];
    assign p3_32 = p3[31:0];
    assign p4_32 = p4[31:0];
    assign p5_32 = p5[31:0];
    assign p6_32 = p6[31:0];
    assign p7_32 = p7[31:0];
    assign p8_32 = p8[31:0];
    assign p9_32 = p9[31:0];

    // global advance: the pipe moves whenever the output register is free or being taken
    logic out_valid_reg;
    logic en;

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    logic [8:0] pre_vld_reg;
    logic [3:0] post_vld_reg;
    logic       div_valid;

    // stage a: temperature products
    logic [ADC_W-1:0] adcp_a_reg, adcp_b_reg, adcp_c_reg, adcp_d_reg;
    logic [ADC_W-1:0] adcp_e_reg, adcp_f_reg, adcp_g_reg;
    logic [31:0]      tx, td;
    logic [31:0]      amul_reg, dd_reg;

    assign tx = {15'd0, in_ch.adc_temperature[19:3]} - {15'd0, t1[15:0], 1'b0};
    assign td = {16'd0, in_ch.adc_temperature[19:4]} - t1;

    // stage b
    logic [31:0] a_b_reg, mb_reg;

    // stage c: fine temperature
    logic [31:0] fine_c_reg;

    // stage d: temperature result and first pressure products
    logic signed [33:0] v1w;
    logic signed [67:0] sq_full;
    logic signed [49:0] v1p5_full, v1p2_full;
    logic [31:0]        fine5, v1n, qn;
    ptc_side_t          side_d_next;
    ptc_side_t          side_d_reg, side_e_reg, side_f_reg, side_g_reg, side_h_reg;
    logic [63:0]        sq_reg, v1p5_reg, v1p2_reg;
    logic [31:0]        qq_reg, v1p5_32_reg, p2v1_32_reg;

    assign fine5   = (fine_c_reg << 2) + fine_c_reg + 32'd128;
    assign v1w     = $signed({{2{fine_c_reg[31]}}, fine_c_reg}) - 34'sd128000;
    assign sq_full = v1w * v1w;
    assign v1p5_full = v1w * $signed(press_hi_reg[15:0]);
    assign v1p2_full = v1w * $signed(press_lo_reg[31:16]);
    assign v1n     = 32'($signed(fine_c_reg) >>> 1) - 32'd64000;
    assign qn      = 32'($signed(v1n) >>> 2);

    always_comb
    begin
        side_d_next      = '0;
        side_d_next.temp = 32'($signed(fine5) >>> 8);
        side_d_next.fine = fine_c_reg;
    end

    // stage e
    logic [63:0] v2a_reg, m3_reg, v1p5_e_reg, v1p2_e_reg;
    logic [31:0] v2a_32_reg, m3_32_reg, v1p5_32_e_reg, p2v1_32_e_reg;

    // stage f: divisor precursors
    logic [63:0] v2_f_next, v1_f_next, v2_f_reg, v1_f_reg;
    logic [31:0] v2t_32, v2_32_f_next, v1_32_f_next, v2_32_f_reg, v1_32_f_reg;

    assign v2_f_next    = v2a_reg + (v1p5_e_reg << 17) + (p4 << 35);
    assign v1_f_next    = 64'($signed(m3_reg) >>> 8) + (v1p2_e_reg << 12);
    assign v2t_32       = v2a_32_reg + (v1p5_32_e_reg << 1);
    assign v2_32_f_next = 32'($signed(v2t_32) >>> 2) + (p4_32 << 16);
    assign v1_32_f_next = 32'($signed(32'($signed(m3_32_reg) >>> 3)
                                      + 32'($signed(p2v1_32_e_reg) >>> 1)) >>> 18);

    // stage g
    logic [63:0] w_reg, v2_g_reg;
    logic [31:0] w32_reg, v2_32_g_reg;

    // stage h: divisor, dividend, zero check
    logic [31:0] pm;
    logic [63:0] dvs64_next, num_base;
    logic [31:0] dvs32_next;
    logic [63:0] num64_reg, dvs64_reg;
    logic [31:0] p32_reg, dvs32_reg;
    ptc_side_t   side_h_next;

    assign pm         = 32'd1048576 - {12'd0, adcp_g_reg};
    assign dvs64_next = 64'($signed(w_reg) >>> 33);
    assign dvs32_next = 32'($signed(w32_reg) >>> 15);
    assign num_base   = {1'b0, pm, 31'd0} - v2_g_reg;

    always_comb
    begin
        side_h_next      = side_g_reg;
        side_h_next.zero = formula_reg ? (dvs32_next == 32'd0) : (dvs64_next == 64'd0);
    end

    // stage i: operand magnitudes for the divider
    ptc_side_t        side_i_next, side_i_reg;
    logic [DIV_W-1:0] dvd_i_next, dvs_i_next, dvd_i_reg, dvs_i_reg;

    always_comb
    begin
        side_i_next = side_h_reg;
        if (formula_reg)
        begin
            side_i_next.dbl = p32_reg[31];
            dvd_i_next      = p32_reg[31] ? {32'd0, p32_reg} : {31'd0, p32_reg, 1'b0};
            dvs_i_next      = {32'd0, dvs32_reg};
        end
        else
        begin
            side_i_next.neg = num64_reg[63] ^ dvs64_reg[63];
            dvd_i_next      = num64_reg[63] ? 64'd0 - num64_reg : num64_reg;
            dvs_i_next      = dvs64_reg[63] ? 64'd0 - dvs64_reg : dvs64_reg;
        end
    end

    logic [DIV_W-1:0] quo;
    ptc_side_t        div_side;

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_vld_reg[8]),
        .in_dvd    (dvd_i_reg),
        .in_dvs    (dvs_i_reg),
        .in_side   (side_i_reg),
        .out_valid (div_valid),
        .out_quo   (quo),
        .out_side  (div_side)
    );

    // stage j: quotient sign and doubling
    logic [63:0] p64_j_reg;
    logic [31:0] p32_j_reg;
    ptc_side_t   side_j_reg, side_k_reg, side_l_reg, side_m_reg;

    // stage k: first correction products
    logic [63:0] ps;
    logic [31:0] p32s3;
    logic [63:0] p64_k_reg, ps_k_reg, t_k_reg, v2m_k_reg;
    logic [31:0] p32_k_reg, aa_k_reg, v2m32_k_reg;

    assign ps    = 64'($signed(p64_j_reg) >>> 13);
    assign p32s3 = p32_j_reg >> 3;

    // stage l: second product split into 32-bit partials
    logic [63:0] m0_reg, p64_l_reg, v2m_l_reg;
    logic [31:0] m1_reg, m2_reg, m32_reg, p32_l_reg, v2m32_l_reg;

    // stage m: correction sums
    logic [63:0] prod, sum_m_next, sum_m_reg;
    logic [31:0] corr32, press32_m_next, press32_m_reg;

    assign prod       = m0_reg + {m1_reg + m2_reg, 32'd0};
    assign sum_m_next = p64_l_reg + 64'($signed(prod) >>> 25)
                        + 64'($signed(v2m_l_reg) >>> 19);
    assign corr32     = 32'($signed(m32_reg) >>> 12) + 32'($signed(v2m32_l_reg) >>> 13)
                        + p7_32;
    assign press32_m_next = p32_l_reg + 32'($signed(corr32) >>> 4);

    // output register
    logic [63:0] press64_fin;
    logic [31:0] press_next;
    logic [31:0] temp_out_reg, fine_out_reg, press_out_reg;
    logic        zero_out_reg;

    assign press64_fin = 64'($signed(sum_m_reg) >>> 8) + (p7 << 4);

    always_comb
    begin
        if (side_m_reg.zero)
            press_next = 32'd0;
        else if (formula_reg)
            press_next = press32_m_reg;
        else
            press_next = press64_fin[31:0];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // a
            adcp_a_reg <= in_ch.adc_pressure;
            amul_reg   <= tx * t2;
            dd_reg     <= td * td;
            // b
            adcp_b_reg <= adcp_a_reg;
            a_b_reg    <= 32'($signed(amul_reg) >>> 11);
            mb_reg     <= 32'($signed(dd_reg) >>> 12) * t3;
            // c
            adcp_c_reg <= adcp_b_reg;
            fine_c_reg <= a_b_reg + 32'($signed(mb_reg) >>> 14);
            // d
            adcp_d_reg  <= adcp_c_reg;
            side_d_reg  <= side_d_next;
            sq_reg      <= sq_full[63:0];
            v1p5_reg    <= {{14{v1p5_full[49]}}, v1p5_full};
            v1p2_reg    <= {{14{v1p2_full[49]}}, v1p2_full};
            qq_reg      <= qn * qn;
            v1p5_32_reg <= v1n * p5_32;
            p2v1_32_reg <= p2_32 * v1n;
            // e
            adcp_e_reg    <= adcp_d_reg;
            side_e_reg    <= side_d_reg;
            v2a_reg       <= sq_reg * p6;
            m3_reg        <= sq_reg * p3;
            v1p5_e_reg    <= v1p5_reg;
            v1p2_e_reg    <= v1p2_reg;
            v2a_32_reg    <= 32'($signed(qq_reg) >>> 11) * p6_32;
            m3_32_reg     <= p3_32 * 32'($signed(qq_reg) >>> 13);
            v1p5_32_e_reg <= v1p5_32_reg;
            p2v1_32_e_reg <= p2v1_32_reg;
            // f
            adcp_f_reg  <= adcp_e_reg;
            side_f_reg  <= side_e_reg;
            v2_f_reg    <= v2_f_next;
            v1_f_reg    <= v1_f_next;
            v2_32_f_reg <= v2_32_f_next;
            v1_32_f_reg <= v1_32_f_next;
            // g
            adcp_g_reg  <= adcp_f_reg;
            side_g_reg  <= side_f_reg;
            w_reg       <= ((64'd1 << 47) + v1_f_reg) * p1;
            w32_reg     <= (32'd32768 + v1_32_f_reg) * p1_32;
            v2_g_reg    <= v2_f_reg;
            v2_32_g_reg <= v2_32_f_reg;
            // h
            side_h_reg <= side_h_next;
            num64_reg  <= num_base * 64'd3125;
            dvs64_reg  <= dvs64_next;
            p32_reg    <= (pm - 32'($signed(v2_32_g_reg) >>> 12)) * 32'd3125;
            dvs32_reg  <= dvs32_next;
            // i
            side_i_reg <= side_i_next;
            dvd_i_reg  <= dvd_i_next;
            dvs_i_reg  <= dvs_i_next;
            // j
            side_j_reg <= div_side;
            p64_j_reg  <= div_side.neg ? 64'd0 - quo : quo;
            p32_j_reg  <= div_side.dbl ? {quo[30:0], 1'b0} : quo[31:0];
            // k
            side_k_reg  <= side_j_reg;
            p64_k_reg   <= p64_j_reg;
            ps_k_reg    <= ps;
            t_k_reg     <= p9 * ps;
            v2m_k_reg   <= p8 * p64_j_reg;
            p32_k_reg   <= p32_j_reg;
            aa_k_reg    <= p32s3 * p32s3;
            v2m32_k_reg <= (p32_j_reg >> 2) * p8_32;
            // l
            side_l_reg  <= side_k_reg;
            m0_reg      <= {32'd0, t_k_reg[31:0]} * {32'd0, ps_k_reg[31:0]};
            m1_reg      <= t_k_reg[63:32] * ps_k_reg[31:0];
            m2_reg      <= t_k_reg[31:0] * ps_k_reg[63:32];
            m32_reg     <= p9_32 * (aa_k_reg >> 13);
            p64_l_reg   <= p64_k_reg;
            v2m_l_reg   <= v2m_k_reg;
            p32_l_reg   <= p32_k_reg;
            v2m32_l_reg <= v2m32_k_reg;
            // m
            side_m_reg    <= side_l_reg;
            sum_m_reg     <= sum_m_next;
            press32_m_reg <= press32_m_next;
            // output
            temp_out_reg  <= side_m_reg.temp;
            fine_out_reg  <= side_m_reg.fine;
            press_out_reg <= press_next;
            zero_out_reg  <= side_m_reg.zero;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg   <= '0;
            post_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_vld_reg   <= {pre_vld_reg[7:0], in_ch.valid};
            post_vld_reg  <= {post_vld_reg[2:0], div_valid};
            out_valid_reg <= post_vld_reg[3];
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.temperature_centi = temp_out_reg;
    assign out_ch.fine_temperature  = fine_out_reg;
    assign out_ch.pressure_value    = press_out_reg;
    assign out_ch.divisor_zero      = zero_out_reg;

endmodule

[src/ptc_div.sv]
module ptc_div
    import ptc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DIV_W-1:0] in_dvd,
    input  logic [DIV_W-1:0] in_dvs,
    input  ptc_side_t        in_side,
    output logic             out_valid,
    output logic [DIV_W-1:0] out_quo,
    output ptc_side_t        out_side
);

    // one quotient bit per stage; the dividend register fills with quotient bits from the lsb
    logic [DIV_W-1:0] rem_reg  [DIV_W];
    logic [DIV_W-1:0] dvd_reg  [DIV_W];
    logic [DIV_W-1:0] dvs_reg  [DIV_W];
    ptc_side_t        side_reg [DIV_W];
    logic [DIV_W-1:0] vld_reg;

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W-1:0] rem_src;
        logic [DIV_W-1:0] dvd_src;
        logic [DIV_W-1:0] dvs_src;
        ptc_side_t        side_src;
        logic             vld_src;
        logic [DIV_W:0]   part;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_src  = '0;
            assign dvd_src  = in_dvd;
            assign dvs_src  = in_dvs;
            assign side_src = in_side;
            assign vld_src  = in_valid;
        end
        else begin : g_next
            assign rem_src  = rem_reg[k-1];
            assign dvd_src  = dvd_reg[k-1];
            assign dvs_src  = dvs_reg[k-1];
            assign side_src = side_reg[k-1];
            assign vld_src  = vld_reg[k-1];
        end

        assign part = {rem_src, dvd_src[DIV_W-1]};
        assign ge   = (part >= {1'b0, dvs_src});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? DIV_W'(part - {1'b0, dvs_src}) : part[DIV_W-1:0];
                dvd_reg[k]  <= {dvd_src[DIV_W-2:0], ge};
                dvs_reg[k]  <= dvs_src;
                side_reg[k] <= side_src;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_src;
        end
    end

    assign out_valid = vld_reg[DIV_W-1];
    assign out_quo   = dvd_reg[DIV_W-1];
    assign out_side  = side_reg[DIV_W-1];

endmodule

[tb/sv/ptc_compensation_checker.sv]
`timescale 1ns / 1ps

module ptc_compensation_checker
    import ptc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ptc_in_if                     in_ch,
    ptc_out_if                    out_ch,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    results_owed
);

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [31:0] press;
        logic        zero;
    } comp_result_t;

    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [15:0] cal_press_nine;
    logic        use_fallback;

    comp_result_t owed_results[$];

    function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] coef64(input logic [15:0] c);
        return {{48{c[15]}}, c};
    endfunction

    // signed divide truncating toward zero, wraps on overflow
    function automatic logic [63:0] sdiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic comp_result_t compensate(input logic [19:0] adcp,
                                                input logic [19:0] adct);
        comp_result_t r;
        logic [31:0] adct32, adcp32, t1, t2, t3, a, b, d;
        logic [63:0] c1, c2, c3, c4, c5, c6, c7, c8, c9, v1, v2, p;
        logic [31:0] w1, w2, q, pp;
        adct32 = {12'd0, adct};
        adcp32 = {12'd0, adcp};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        c1 = {48'd0, cal_press_lo[15:0]};
        c2 = coef64(cal_press_lo[31:16]);
        c3 = coef64(cal_press_lo[47:32]);
        c4 = coef64(cal_press_lo[63:48]);
        c5 = coef64(cal_press_hi[15:0]);
        c6 = coef64(cal_press_hi[31:16]);
        c7 = coef64(cal_press_hi[47:32]);
        c8 = coef64(cal_press_hi[63:48]);
        c9 = coef64(cal_press_nine);

        a = sra32(((adct32 >> 3) - (t1 << 1)) * t2, 11);
        d = (adct32 >> 4) - t1;
        b = sra32(sra32(d * d, 12) * t3, 14);
        r.fine  = a + b;
        r.temp  = sra32(r.fine * 32'd5 + 32'd128, 8);
        r.press = '0;
        r.zero  = 1'b0;

        if (!use_fallback) begin
            v1 = {{32{r.fine[31]}}, r.fine} - 64'd128000;
            v2 = v1 * v1 * c6;
            v2 = v2 + ((v1 * c5) << 17);
            v2 = v2 + (c4 << 35);
            v1 = sra64(v1 * v1 * c3, 8) + ((v1 * c2) << 12);
            v1 = sra64(((64'd1 << 47) + v1) * c1, 33);
            if (v1 == '0) begin
                r.zero = 1'b1;
            end
            else begin
                p  = 64'd1048576 - {44'd0, adcp};
                p  = sdiv64(((p << 31) - v2) * 64'd3125, v1);
                v1 = sra64(c9 * sra64(p, 13) * sra64(p, 13), 25);
                v2 = sra64(c8 * p, 19);
                p  = sra64(p + v1 + v2, 8) + (c7 << 4);
                r.press = p[31:0];
            end
        end
        else begin
            w1 = sra32(r.fine, 1) - 32'd64000;
            q  = sra32(w1, 2);
            w2 = sra32(q * q, 11) * c6[31:0];
            w2 = w2 + ((w1 * c5[31:0]) << 1);
            w2 = sra32(w2, 2) + (c4[31:0] << 16);
            w1 = sra32(sra32(c3[31:0] * sra32(q * q, 13), 3) + sra32(c2[31:0] * w1, 1), 18);
            w1 = sra32((32'd32768 + w1) * c1[31:0], 15);
            if (w1 == '0) begin
                r.zero = 1'b1;
            end
            else begin
                pp = ((32'd1048576 - adcp32) - sra32(w2, 12)) * 32'd3125;
                if (pp < 32'h8000_0000)
                    pp = (pp << 1) / w1;
                else
                    pp = (pp / w1) * 32'd2;
                w1 = sra32(c9[31:0] * (((pp >> 3) * (pp >> 3)) >> 13), 12);
                w2 = sra32((pp >> 2) * c8[31:0], 13);
                pp = pp + sra32(w1 + w2 + c7[31:0], 4);
                r.press = pp;
            end
        end
        return r;
    endfunction

    assign results_owed = owed_results.size();

    always @(posedge clk or negedge rst_n) begin
        comp_result_t want;
        comp_result_t got;
        if (!rst_n) begin
            cal_temp       <= '0;
            cal_press_lo   <= '0;
            cal_press_hi   <= '0;
            cal_press_nine <= '0;
            use_fallback   <= 1'b0;
            mismatch_count <= 0;
            owed_results.delete();
        end
        else begin
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_TEMP_CAL:   cal_temp       <= cfg_wdata[47:0];
                    CFG_PRESS_LO:   cal_press_lo   <= cfg_wdata;
                    CFG_PRESS_HI:   cal_press_hi   <= cfg_wdata;
                    CFG_PRESS_NINE: cal_press_nine <= cfg_wdata[15:0];
                    CFG_FORMULA:    use_fallback   <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                owed_results.push_back(compensate(in_ch.adc_pressure, in_ch.adc_temperature));
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.temperature_centi, out_ch.fine_temperature,
                       out_ch.pressure_value, out_ch.divisor_zero};
                if (owed_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result transaction: %h", got);
                    mismatch_count <= mismatch_count + 1;
                end
                else begin
                    want = owed_results.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10)
                            $display("mismatch: temp %h/%h fine %h/%h press %h/%h zero %b/%b",
                                     want.temp, got.temp, want.fine, got.fine,
                                     want.press, got.press, want.zero, got.zero);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/sv/tb_pressure_temperature_compensation.sv]
`timescale 1ns / 1ps

module tb_pressure_temperature_compensation;
    import ptc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int mismatch_count;
    int results_owed;
    int quiet_cycles;

    ptc_in_if  in_ch ();
    ptc_out_if out_ch ();

    pressure_temperature_compensation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ptc_compensation_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        bit hold_taken;
        hold_taken   = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken   = 1'b1;
                out_ch.ready = 1'b0;
                // long stall so the pipe fills and in_ch.ready drops
                repeat (300) @(negedge clk);
            end
            out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles with no transaction on either channel
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // one sample pair, with random idle cycles ahead of it
    task automatic send_sample(input logic [ADC_W-1:0] adcp, input logic [ADC_W-1:0] adct);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid           = 1'b1;
        in_ch.adc_pressure    = adcp;
        in_ch.adc_temperature = adct;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_random_sample();
        logic [ADC_W-1:0] adcp;
        logic [ADC_W-1:0] adct;
        case ($urandom_range(3))
            0, 1:
            begin
                // plausible conversions around room conditions
                adcp = ADC_W'($urandom_range(450000, 250000));
                adct = ADC_W'($urandom_range(600000, 400000));
            end
            2:
            begin
                adcp = ADC_W'($urandom);
                adct = ADC_W'($urandom);
            end
            default:
            begin
                adcp = $urandom_range(1) ? '1 : ADC_W'($urandom_range(15));
                adct = $urandom_range(1) ? '1 : ADC_W'($urandom);
            end
        endcase
        send_sample(adcp, adct);
    endtask

    // configuration only while nothing is in flight
    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (results_owed != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_wen   = 1'b0;
    endtask

    task automatic load_calibration(input logic [47:0] tcal, input logic [63:0] plo,
                                    input logic [63:0] phi, input logic [15:0] p9,
                                    input logic fallback);
        wait_idle();
        write_reg(CFG_TEMP_CAL, {16'd0, tcal});
        write_reg(CFG_PRESS_LO, plo);
        write_reg(CFG_PRESS_HI, phi);
        write_reg(CFG_PRESS_NINE, {48'd0, p9});
        write_reg(CFG_FORMULA, {63'd0, fallback});
    endtask

    // typical factory coefficients
    localparam logic [47:0] TYP_TCAL = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PLO  = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PHI  = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [15:0] TYP_P9   = 16'd6000;

    initial
    begin
        logic [47:0] tcal;
        logic [63:0] plo;
        logic [63:0] phi;
        in_ch.valid           = 1'b0;
        in_ch.adc_pressure    = '0;
        in_ch.adc_temperature = '0;
        cfg_wen               = 1'b0;
        cfg_index             = '0;
        cfg_wdata             = '0;
        send_idle_pct         = 32;
        recv_idle_pct         = 76;
        hold_request          = 1'b0;
        rst_n                 = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset calibration is all zero, so the divisor is zero
        send_sample('0, '0);
        send_sample('1, '1);
        send_sample(20'h55555, 20'hAAAAA);

        // directed samples on typical coefficients, both formulas
        for (int f = 0; f < 2; f++)
        begin
            load_calibration(TYP_TCAL, TYP_PLO, TYP_PHI, TYP_P9, f[0]);
            send_sample('0, '0);
            send_sample('1, '1);
            send_sample('0, '1);
            send_sample('1, '0);
            send_sample(20'hAAAAA, 20'h55555);
            send_sample(20'h55555, 20'hAAAAA);
            send_sample(20'd415148, 20'd519888);
            send_sample(20'd1, 20'd8);
            send_sample(20'h80000, 20'h80000);
        end

        // zero P1 forces the zero divisor in both formulas
        load_calibration(TYP_TCAL, {TYP_PLO[63:16], 16'd0}, TYP_PHI, TYP_P9, 1'b0);
        send_sample(20'd415148, 20'd519888);
        wait_idle();
        write_reg(CFG_FORMULA, 64'd1);
        send_sample(20'd415148, 20'd519888);

        // unmapped index must leave every register alone
        wait_idle();
        cfg_wen   = 1'b1;
        cfg_index = CFG_IDX_W'(CFG_FORMULA) + 1'b1;
        cfg_wdata = '1;
        @(negedge clk);
        cfg_index = '1;
        @(negedge clk);
        cfg_wen = 1'b0;
        send_sample(20'd300000, 20'd500000);

        // random part: ten calibration sets, idle pattern changes over the run
        for (int k = 0; k < 10; k++)
        begin
            if (k == 3)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 32;
            end
            else if (k == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (k)
                0: load_calibration(TYP_TCAL, TYP_PLO, TYP_PHI, TYP_P9, 1'b0);
                1: load_calibration(TYP_TCAL, TYP_PLO, TYP_PHI, TYP_P9, 1'b1);
                2: load_calibration('1, '1, '1, '1, 1'b0);
                3: load_calibration('1, '1, '1, '1, 1'b1);
                4: load_calibration('0, '0, '0, '0, 1'b0);
                default:
                begin
                    tcal = {$urandom, $urandom};
                    plo  = {$urandom, $urandom};
                    phi  = {$urandom, $urandom};
                    // sometimes keep the pressure terms near typical
                    if ($urandom_range(1))
                    begin
                        plo = TYP_PLO ^ 64'($urandom_range(255));
                        phi = TYP_PHI ^ 64'($urandom_range(255));
                    end
                    load_calibration(tcal, plo, phi, 16'($urandom), k[0]);
                end
            endcase
            for (int n = 0; n < 112; n++)
            begin
                if (k == 1 && n == 20)
                    hold_request = 1'b1;
                if (k == 7 && n == 50)
                begin
                    // sender holds back until every result is home
                    in_ch.valid = 1'b0;
                    while (results_owed != 0) @(negedge clk);
                end
                send_random_sample();
            end
        end
        in_ch.valid = 1'b0;

        while (results_owed != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
